>>> rtl/core/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// shared widths and request/status codes for the page bitmap allocator
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 10;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 11;

  // bitmap row geometry
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

endpackage

>>> rtl/core/pba_if.sv
// ----------------------------------------------------------------------------
// pba_if
// request and response channels of the page bitmap allocator
// ----------------------------------------------------------------------------
interface pba_req_if
  import pba_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   page_id;

  modport source (output valid, output func, output page_id, input ready);
  modport sink   (input valid, input func, input page_id, output ready);
endinterface

interface pba_rsp_if
  import pba_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     result_id;
  logic [STATUS_W-1:0] status;
  logic                in_use;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    used_count;

  modport source (output valid, output result_id, output status, output in_use,
                  output free_count, output used_count, input ready);
  modport sink   (input valid, input result_id, input status, input in_use,
                  input free_count, input used_count, output ready);
endinterface

>>> rtl/core/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/page_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top
// first-fit page allocator over a free-page bitmap held in ram
// ----------------------------------------------------------------------------
// usage:
//   req carries one transaction per request: func (allocate, free, query)
//   and page_id. rsp returns exactly one transaction per request with the
//   allocated id, a status, the query answer and the free/used counts as
//   they stand after the request.
//   the bitmap lives in a ram of 32-bit rows, one bit per page, 1 = free.
//   page 0 is reserved and never handed out or freed.
// scan and sequencing:
//   allocate scans rows from the bottom, one row per cycle through the ram
//   read port and a shared lowest-set-bit unit, and stops at the first row
//   that holds a free page (32 rows for 1024 pages).
//   free and query read one row; invalid ids and unused codes read none.
//   one request is in flight at a time, up to the rsp output register.
// reset:
//   rst (synchronous) starts a clearing pass that writes every bitmap row,
//   during which req.ready stays low.
// stall:
//   a finished result sits in the rsp output register; a new request is
//   taken while it waits, but its result is held until rsp.ready frees the
//   register.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top
  import pba_pkg::*;
#(
  parameter int PAGES = 1024
) (
  input  logic      clk,
  input  logic      rst,
  pba_req_if.sink   req,
  pba_rsp_if.source rsp
);

  // bitmap geometry
  localparam int WORDS    = (PAGES + WORD_W - 1) / WORD_W;
  localparam int ROW_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W    = (ROW_W + BIT_W > ID_W) ? ROW_W + BIT_W : ID_W;
  localparam int TOT_W    = $clog2(PAGES);
  localparam int REM      = PAGES - (WORDS - 1) * WORD_W;
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(WORDS - 1);
  localparam logic [WORD_W-1:0] LAST_MASK =
    (REM >= WORD_W) ? '1 : WORD_W'((64'd1 << REM) - 64'd1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t              state;
  logic [ROW_W-1:0]    row;
  logic [FUNC_W-1:0]   func_r;
  logic [ID_W-1:0]     id_r;
  logic [TOT_W-1:0]    free_total;
  logic [ID_W-1:0]     res_id;
  logic [STATUS_W-1:0] res_status;
  logic                res_in_use;

  // output register
  logic                out_valid;
  logic [ID_W-1:0]     out_id;
  logic [STATUS_W-1:0] out_status;
  logic                out_in_use;
  logic [CNT_W-1:0]    out_free;
  logic [CNT_W-1:0]    out_used;

  // ram port
  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [ROW_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  // request decode
  logic                accept;
  logic                req_id_ok;
  logic [IDX_W-1:0]    req_id_wide;
  logic [ROW_W-1:0]    req_row;

  // shared row evaluation unit
  logic [WORD_W-1:0]   low_bit;
  logic [BIT_W-1:0]    low_idx;
  logic                row_found;
  logic [BIT_W-1:0]    sel_bit;
  logic                sel_free;
  logic [WORD_W-1:0]   init_word;
  logic                out_load;

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == S_IDLE);
  assign req_id_ok   = (req.page_id != '0) && (32'(req.page_id) < 32'(PAGES));
  assign req_id_wide = IDX_W'(req.page_id);
  assign req_row     = req_id_wide[ROW_W+BIT_W-1:BIT_W];

  // isolate the lowest set bit and encode its position
  assign low_bit   = ram_rdata & (~ram_rdata + WORD_W'(1));
  assign row_found = (ram_rdata != '0);
  always_comb begin
    low_idx = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (low_bit[j]) begin
        low_idx = low_idx | BIT_W'(j);
      end
    end
  end

  assign sel_bit  = id_r[BIT_W-1:0];
  assign sel_free = ram_rdata[sel_bit];

  // reset contents of a row: pages past PAGES and page 0 read as used
  always_comb begin
    init_word = (row == LAST_ROW) ? LAST_MASK : '1;
    if (row == '0) begin
      init_word[0] = 1'b0;
    end
  end

  // ram control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row;
    ram_wdata = init_word;
    ram_raddr = row;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = (req.func == FUNC_ALLOC) ? '0 : req_row;
      end
      S_EVAL: begin
        // prefetch the next row so the scan moves one row per cycle
        ram_raddr = (row == LAST_ROW) ? row : row + ROW_W'(1);
        if (func_r == FUNC_ALLOC) begin
          ram_we    = row_found;
          ram_wdata = ram_rdata & ~low_bit;
        end else if (func_r == FUNC_FREE) begin
          ram_we    = !sel_free;
          ram_wdata = ram_rdata | (WORD_W'(1) << sel_bit);
        end
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  pba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_load = (state == S_FINISH) && (!out_valid || rsp.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      row        <= '0;
      free_total <= TOT_W'(PAGES - 1);
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (row == LAST_ROW) begin
            row   <= '0;
            state <= S_IDLE;
          end else begin
            row <= row + ROW_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_r     <= req.func;
            id_r       <= req.page_id;
            res_id     <= '0;
            res_status <= STATUS_OK;
            res_in_use <= 1'b0;
            priority if (req.func == FUNC_ALLOC) begin
              row   <= '0;
              state <= S_EVAL;
            end else if (req.func == FUNC_FREE || req.func == FUNC_QUERY) begin
              row <= req_row;
              if (req_id_ok) begin
                state <= S_EVAL;
              end else begin
                res_status <= STATUS_BAD;
                state      <= S_FINISH;
              end
            end else begin
              // unused request code: report counts only
              state <= S_FINISH;
            end
          end
        end
        S_EVAL: begin
          priority if (func_r == FUNC_ALLOC) begin
            if (row_found) begin
              res_id     <= ID_W'({row, low_idx});
              free_total <= free_total - TOT_W'(1);
              state      <= S_FINISH;
            end else if (row == LAST_ROW) begin
              res_status <= STATUS_FULL;
              state      <= S_FINISH;
            end else begin
              row <= row + ROW_W'(1);
            end
          end else if (func_r == FUNC_FREE) begin
            if (!sel_free) begin
              free_total <= free_total + TOT_W'(1);
            end
            state <= S_FINISH;
          end else begin
            res_in_use <= !sel_free;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id     <= res_id;
      out_status <= res_status;
      out_in_use <= res_in_use;
      out_free   <= CNT_W'(free_total);
      out_used   <= CNT_W'(32'(PAGES) - 32'(free_total));
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.result_id  = out_id;
  assign rsp.status     = out_status;
  assign rsp.in_use     = out_in_use;
  assign rsp.free_count = out_free;
  assign rsp.used_count = out_used;

  // checks
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    32'(free_total) <= 32'(PAGES - 1))
    else $error("free page total exceeds the number of allocatable pages");

  a_ram_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_EVAL))
    else $error("bitmap written outside clearing pass or row evaluation");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && func_r == FUNC_ALLOC && row_found)
      |=> free_total == $past(free_total) - TOT_W'(1))
    else $error("allocation did not take one page off the free total");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !rsp.ready) |=> state == S_FINISH)
    else $error("finished result left while the output register was full");

endmodule

>>> tb/page_bitmap_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top_tb
// self-checking bench for the first-fit page allocator
// ----------------------------------------------------------------------------
// a ledger object keeps its own copy of the free-page bitmap and free count.
// it predicts one response per accepted request and compares every returned
// response against the oldest prediction. a directed opener hits the
// reserved page, the top id, double free and the unused request code.
// random traffic then runs in three phases:
//   - mixed traffic
//   - an allocation-heavy fill that runs the map full and keeps going past
//     it, so frees punch holes that later allocates must find again
//   - free-heavy traffic with a long response hold-off that backs the block
//     up onto its request port
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top_tb;
  import pba_pkg::*;

  localparam int PAGES = 1024;
  localparam int QUIET_LIMIT = 2000;
  localparam int RSP_HOLD_CYCLES = 400;
  // drain wait covers an allocate scan over every bitmap row
  localparam int DRAIN_CYCLES = PAGES / WORD_W + 8;
  // request code the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]     result_id;
    logic [STATUS_W-1:0] status;
    logic                in_use;
    logic [CNT_W-1:0]    free_count;
    logic [CNT_W-1:0]    used_count;
  } page_rsp_t;

  // --------------------------------------------------------------------------
  // ledger: bitmap shadow plus the queue of responses still owed by the block
  // --------------------------------------------------------------------------
  class page_ledger;
    bit          free_map[PAGES];
    int unsigned free_total;
    page_rsp_t   awaited_rsp[$];
    int unsigned mismatches;

    function new();
      foreach (free_map[i]) free_map[i] = 1'b1;
      free_map[0] = 1'b0;
      free_total  = PAGES - 1;
      mismatches  = 0;
    endfunction

    // apply one accepted request transaction and queue the response it owes
    function void note_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] page_id);
      page_rsp_t rsp;
      bit        id_ok;
      int        i;
      rsp   = '0;
      id_ok = (page_id != 0) && (int'(page_id) < PAGES);
      case (func)
        FUNC_ALLOC: begin
          rsp.status = STATUS_FULL;
          for (i = 1; i < PAGES; i++) begin
            if (free_map[i]) begin
              free_map[i]   = 1'b0;
              free_total--;
              rsp.result_id = ID_W'(i);
              rsp.status    = STATUS_OK;
              break;
            end
          end
        end
        FUNC_FREE: begin
          if (!id_ok) begin
            rsp.status = STATUS_BAD;
          end else if (!free_map[page_id]) begin
            free_map[page_id] = 1'b1;
            free_total++;
          end
        end
        FUNC_QUERY: begin
          if (!id_ok) rsp.status = STATUS_BAD;
          else        rsp.in_use = !free_map[page_id];
        end
        default: ;
      endcase
      rsp.free_count = CNT_W'(free_total);
      rsp.used_count = CNT_W'(PAGES - free_total);
      awaited_rsp.push_back(rsp);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(page_rsp_t got);
      page_rsp_t want;
      if (awaited_rsp.size() == 0) begin
        $error("response transaction with none outstanding: result_id %0d status %0d",
               got.result_id, got.status);
        mismatches++;
        return;
      end
      want = awaited_rsp.pop_front();
      compare_field("result_id", 16'(want.result_id), 16'(got.result_id));
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("in_use", 16'(want.in_use), 16'(got.in_use));
      compare_field("free_count", 16'(want.free_count), 16'(got.free_count));
      compare_field("used_count", 16'(want.used_count), 16'(got.used_count));
    endfunction
  endclass

  logic clk;
  logic rst;

  pba_req_if req_ch ();
  pba_rsp_if rsp_ch ();

  page_bitmap_allocator_top #(
    .PAGES(PAGES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  page_ledger  ledger;
  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;
  bit          hold_armed;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // known values on every block input from time zero
  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.func    = FUNC_ALLOC;
    req_ch.page_id = '0;
    rsp_ch.ready   = 1'b0;
    req_idle_pct   = 0;
    rsp_idle_pct   = 0;
    hold_armed     = 1'b0;
    quiet_cycles   = 0;
    ledger         = new();
  end

  // --------------------------------------------------------------------------
  // response side: random back-pressure, plus one long hold-off once armed
  // the hold is counted here so the request side keeps offering throughout
  // --------------------------------------------------------------------------
  initial begin : rsp_ready_drive
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // every accepted response transaction goes to the ledger
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      ledger.check_result('{result_id:  rsp_ch.result_id,
                            status:     rsp_ch.status,
                            in_use:     rsp_ch.in_use,
                            free_count: rsp_ch.free_count,
                            used_count: rsp_ch.used_count});
    end
  end

  // watchdog: too long without any transaction on either channel ends the run
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("page_bitmap_allocator_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // each call starts and ends on a falling edge; random idle cycles come
  // first, then the transaction is held until the block takes it
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [ID_W-1:0]   page_id);
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= func;
    req_ch.page_id <= page_id;
    do @(posedge clk); while (!req_ch.ready);
    ledger.note_request(func, page_id);
    @(negedge clk);
  endtask

  // page ids: row and map extremes, ids near the allocated region (so frees
  // and queries mostly hit used pages), and the full 10-bit range
  function automatic logic [ID_W-1:0] pick_page_id();
    int unsigned roll;
    int unsigned used_top;
    roll     = $urandom_range(99);
    used_top = PAGES - ledger.free_total + 8;
    if (used_top > PAGES - 1) used_top = PAGES - 1;
    if (roll < 15) begin
      case ($urandom_range(5))
        0:       return '0;
        1:       return ID_W'(1);
        2:       return '1;
        3:       return ID_W'(WORD_W - 1);
        4:       return ID_W'(WORD_W);
        default: return ID_W'(PAGES / 2);
      endcase
    end else if (roll < 55) begin
      return ID_W'($urandom_range(used_top, 1));
    end
    return ID_W'($urandom());
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(int unsigned alloc_pct,
                                                  int unsigned free_pct,
                                                  int unsigned query_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < alloc_pct)                       return FUNC_ALLOC;
    if (roll < alloc_pct + free_pct)            return FUNC_FREE;
    if (roll < alloc_pct + free_pct + query_pct) return FUNC_QUERY;
    return FUNC_UNUSED;
  endfunction

  initial begin : stimulus
    int unsigned after_full;
    after_full = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase 1: sender idles often, receiver idles more
    req_idle_pct = 32;
    rsp_idle_pct = 70;

    // directed opener: reserved page, top id, double free, unused code
    send_request(FUNC_QUERY, '0);
    send_request(FUNC_QUERY, ID_W'(1));
    send_request(FUNC_QUERY, '1);
    send_request(FUNC_FREE, '0);
    send_request(FUNC_FREE, '1);
    send_request(FUNC_ALLOC, '1);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_QUERY, ID_W'(1));
    send_request(FUNC_FREE, ID_W'(1));
    send_request(FUNC_FREE, ID_W'(1));
    send_request(FUNC_QUERY, ID_W'(1));
    send_request(FUNC_ALLOC, ID_W'(10'h2AA));
    send_request(FUNC_ALLOC, ID_W'(10'h155));
    send_request(FUNC_UNUSED, '1);
    send_request(FUNC_UNUSED, '0);
    send_request(FUNC_FREE, ID_W'(2));
    send_request(FUNC_QUERY, ID_W'(2));
    send_request(FUNC_QUERY, ID_W'(3));
    send_request(FUNC_ALLOC, ID_W'(10'h3FF));
    send_request(FUNC_FREE, ID_W'(WORD_W));
    send_request(FUNC_QUERY, ID_W'(10'h155));

    repeat (400) send_request(pick_func(55, 20, 18), pick_page_id());

    // phase 2: roles of the two sides swap; fill the map, then keep going
    // past full so allocates see no free page and frees reopen random holes
    req_idle_pct = 70;
    rsp_idle_pct = 32;
    while (after_full < 120) begin
      if (ledger.free_total != 0 && after_full == 0)
        send_request(pick_func(90, 0, 10), pick_page_id());
      else
        send_request(pick_func(40, 35, 20), pick_page_id());
      if (ledger.free_total == 0 || after_full > 0) after_full++;
    end

    // phase 3: no idling; free-heavy, with one long response hold-off
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_armed   = 1'b1;
    repeat (350) send_request(pick_func(30, 45, 18), pick_page_id());

    req_ch.valid <= 1'b0;

    // drain, then give any stray response time to show up
    while (ledger.awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.mismatches == 0) begin
      $display("page_bitmap_allocator_top verification clean");
    end else begin
      $display("page_bitmap_allocator_top verification failed");
    end
    $finish;
  end

endmodule
